@@ rtl/mpt_pkg.sv @@
`default_nettype none
// ============================================================================
// mpt_pkg
// Shared types and constants of the multichannel PWM timetable.
// ============================================================================
package mpt_pkg;

    localparam int PINS_W       = 8;
    localparam int LVL_W        = 8;
    localparam int CHAN_W       = 3;
    localparam int CHANNELS_DEF = 8;

    localparam logic [LVL_W-1:0] LVL_OFF  = 8'd0;
    localparam logic [LVL_W-1:0] LVL_FULL = 8'd255;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [CHAN_W-1:0] channel;
        logic [LVL_W-1:0]  brightness;
        logic              last;
    } t_in_word;

    typedef struct packed {
        logic [PINS_W-1:0] pins;
    } t_out_word;

    // broadcast control for every cell
    typedef struct packed {
        logic              load_en;
        logic              clear;
        logic              commit;
        logic [LVL_W-1:0]  level;
        logic [PINS_W-1:0] pin_bit;
    } t_cell_ctl;

    // neighbor link, passed left to right
    typedef struct packed {
        logic              valid;
        logic              less;
        logic              shift;
        logic [LVL_W-1:0]  level;
        logic [PINS_W-1:0] mask;
    } t_cell_link;

    typedef struct packed {
        logic hit;
        logic ins;
    } t_cell_stat;

    typedef struct packed {
        logic              valid;
        logic [LVL_W-1:0]  level;
        logic [PINS_W-1:0] mask;
    } t_cell_entry;

endpackage

`default_nettype wire

@@ rtl/mpt_stream_if.sv @@
`default_nettype none
// ============================================================================
// mpt_stream_if
// Valid/ready channel carrying one word of payload type T.
// ============================================================================
interface mpt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/mpt_cell.sv @@
`default_nettype none
// ============================================================================
// mpt_cell
// One timetable slot: staged entry with sorted insert, active copy on commit.
// ============================================================================
module mpt_cell
    import mpt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cell_ctl   i_ctl,
    input  wire logic        i_room,
    input  wire t_cell_link  i_link,
    output t_cell_link       o_link,
    output t_cell_stat       o_stat,
    output t_cell_entry      o_active
);

    logic              r_s_valid, n_s_valid;
    logic [LVL_W-1:0]  r_s_level, n_s_level;
    logic [PINS_W-1:0] r_s_mask,  n_s_mask;
    logic              r_a_valid;
    logic [LVL_W-1:0]  r_a_level;
    logic [PINS_W-1:0] r_a_mask;

    logic valid_eff, own_less, own_eq, pos_here, hit, ins;

    always_comb begin
        valid_eff = r_s_valid && !i_ctl.clear;
        own_less  = valid_eff && (r_s_level < i_ctl.level);
        own_eq    = valid_eff && (r_s_level == i_ctl.level);
        pos_here  = i_ctl.load_en && i_link.less && !own_less;
        hit       = pos_here && own_eq;
        ins       = pos_here && !own_eq && i_room;

        n_s_valid = valid_eff;
        n_s_level = r_s_level;
        n_s_mask  = r_s_mask;
        priority if (ins) begin
            n_s_valid = 1'b1;
            n_s_level = i_ctl.level;
            n_s_mask  = i_ctl.pin_bit;
        end else if (i_link.shift) begin
            n_s_valid = i_link.valid;
            n_s_level = i_link.level;
            n_s_mask  = i_link.mask;
        end else if (hit) begin
            n_s_mask  = r_s_mask | i_ctl.pin_bit;
        end

        o_link.valid = valid_eff;
        o_link.less  = own_less;
        o_link.shift = i_link.shift || ins;
        o_link.level = r_s_level;
        o_link.mask  = r_s_mask;
        o_stat.hit   = hit;
        o_stat.ins   = ins;
        o_active.valid = r_a_valid;
        o_active.level = r_a_level;
        o_active.mask  = r_a_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_a_valid <= 1'b0;
        end else begin
            r_s_valid <= n_s_valid;
            if (i_ctl.commit) begin
                r_a_valid <= r_s_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s_level <= n_s_level;
        r_s_mask  <= n_s_mask;
        if (i_ctl.commit) begin
            r_a_level <= r_s_level;
            r_a_mask  <= r_s_mask;
        end
    end

endmodule

`default_nettype wire

@@ rtl/multichannel_pwm_timetable.sv @@
`default_nettype none
// ============================================================================
// multichannel_pwm_timetable
// Multi-channel 8-bit PWM driven by a sorted switch-off timetable.
// ============================================================================
// Channels: i_in carries tick and load words, o_out returns one pins word
// per accepted input word. Loads insert a channel level into a row of
// CHANNELS cells that keep the staging table sorted; the insert, merge or
// shift completes inside the cell chain. A load with last set
// marks the table pending; the next counter wrap copies it to the active
// table held in the same cells.
// Latency: the pins word for an input word is presented the cycle after the
// word is accepted. Throughput: one word per cycle, set by the single output
// register (a new word is taken while the held result is taken).
// Reset: all tables empty, counter, pins and batch state zero, no result
// held. When the receiver stalls, the result is held in o_out and i_in.ready
// drops until it is taken.
// ============================================================================
module multichannel_pwm_timetable
    import mpt_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    mpt_stream_if.sink   i_in,
    mpt_stream_if.source o_out
);

    localparam int ENT_W = $clog2(CHANNELS + 1);
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_cell_ctl   cell_ctl;
    t_cell_link  link [CHANNELS+1];
    t_cell_stat  stat [CHANNELS];
    t_cell_entry act  [CHANNELS];

    logic              r_out_valid;
    logic [PINS_W-1:0] r_out_pins;
    logic [PINS_W-1:0] r_pin_state,  n_pin_state;
    logic [PINS_W-1:0] r_s_on_mask,  n_s_on_mask;
    logic [PINS_W-1:0] r_a_on_mask,  n_a_on_mask;
    logic [LVL_W-1:0]  r_tick,       n_tick;
    logic [ENT_W-1:0]  r_entry_index, n_entry_index;
    logic              r_commit_pending, n_commit_pending;
    logic              r_batch_open,     n_batch_open;

    logic              in_acc, is_load, is_tick, clear, ch_ok, lvl_mid, wrap;
    logic              any_hit, any_ins, cur_in, cur_ok;
    logic [PINS_W-1:0] pin_bit;
    logic [IDX_W-1:0]  idx;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.data.pins = r_out_pins;

    always_comb begin
        is_load = in_acc && (i_in.data.opcode == OP_LOAD);
        is_tick = in_acc && (i_in.data.opcode == OP_TICK);
        clear   = is_load && !r_batch_open;
        ch_ok   = 32'(i_in.data.channel) < CHANNELS;
        lvl_mid = ch_ok && (i_in.data.brightness != LVL_OFF)
                  && (i_in.data.brightness != LVL_FULL);
        pin_bit = PINS_W'(1) << i_in.data.channel;
        n_tick  = r_tick + LVL_W'(1);
        wrap    = (n_tick == LVL_W'(0));

        cell_ctl.load_en = is_load && lvl_mid;
        cell_ctl.clear   = clear;
        cell_ctl.commit  = is_tick && wrap && r_commit_pending;
        cell_ctl.level   = i_in.data.brightness;
        cell_ctl.pin_bit = pin_bit;

        link[0].valid = 1'b1;
        link[0].less  = 1'b1;
        link[0].shift = 1'b0;
        link[0].level = LVL_OFF;
        link[0].mask  = '0;
    end

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        mpt_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (cell_ctl),
            .i_room   (!link[CHANNELS].valid),
            .i_link   (link[g]),
            .o_link   (link[g+1]),
            .o_stat   (stat[g]),
            .o_active (act[g])
        );
    end

    always_comb begin
        any_hit = 1'b0;
        any_ins = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            any_hit = any_hit | stat[i].hit;
            any_ins = any_ins | stat[i].ins;
        end
    end

    always_comb begin
        idx    = r_entry_index[IDX_W-1:0];
        cur_in = r_entry_index < ENT_W'(CHANNELS);
        cur_ok = cur_in && act[idx].valid;

        n_pin_state      = r_pin_state;
        n_s_on_mask      = r_s_on_mask;
        n_a_on_mask      = r_a_on_mask;
        n_entry_index    = r_entry_index;
        n_commit_pending = r_commit_pending;
        n_batch_open     = r_batch_open;

        if (is_load) begin
            if (clear) begin
                n_s_on_mask      = '0;
                n_commit_pending = 1'b0;
            end
            if ((ch_ok && (i_in.data.brightness == LVL_FULL)) || any_hit || any_ins) begin
                n_s_on_mask = n_s_on_mask | pin_bit;
            end
            if (i_in.data.last) begin
                n_commit_pending = 1'b1;
                n_batch_open     = 1'b0;
            end else begin
                n_batch_open     = 1'b1;
            end
        end

        if (is_tick) begin
            if (wrap) begin
                if (r_commit_pending) begin
                    n_a_on_mask      = r_s_on_mask;
                    n_commit_pending = 1'b0;
                end
                n_pin_state   = n_a_on_mask;
                n_entry_index = '0;
            end else if (cur_ok && (n_tick == act[idx].level)) begin
                n_pin_state   = r_pin_state & ~act[idx].mask;
                n_entry_index = r_entry_index + ENT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid      <= 1'b0;
            r_pin_state      <= '0;
            r_s_on_mask      <= '0;
            r_a_on_mask      <= '0;
            r_tick           <= '0;
            r_entry_index    <= '0;
            r_commit_pending <= 1'b0;
            r_batch_open     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (is_tick) begin
                r_tick <= n_tick;
            end
            r_pin_state      <= n_pin_state;
            r_s_on_mask      <= n_s_on_mask;
            r_a_on_mask      <= n_a_on_mask;
            r_entry_index    <= n_entry_index;
            r_commit_pending <= n_commit_pending;
            r_batch_open     <= n_batch_open;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_pins <= n_pin_state;
        end
    end

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_index <= ENT_W'(CHANNELS))
        else $error("entry index past table end");

    a_wrap_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (is_tick && (r_tick == LVL_FULL)) |=> (r_entry_index == '0))
        else $error("entry index not restarted on wrap");

    a_out_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pins == r_pin_state))
        else $error("held pins word differs from pin state");

    a_load_keeps_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_load |=> (r_pin_state == $past(r_pin_state)))
        else $error("load changed the pins");
`endif

endmodule

`default_nettype wire

@@ test/tb_multichannel_pwm_timetable.sv @@
`default_nettype none
// ============================================================================
// tb_multichannel_pwm_timetable
// Self-checking bench for the sorted-timetable PWM block.
// Tick and load words go in over a valid/ready channel. A behavioral model of
// the staging and active tables predicts the pins word for each accepted
// word. Directed tests cover sorted tables, shared and extreme levels,
// channels loaded twice in one batch, table overflow and a pending commit
// that a new batch cancels. Random batches followed by tick runs, and runs
// of random words, make up the rest. Both sides idle at random, and the
// receiver holds off once for a long stretch.
// ============================================================================
module tb_multichannel_pwm_timetable;
    timeunit 1ns;
    timeprecision 1ps;

    import mpt_pkg::*;

    localparam int NCH          = CHANNELS_DEF;
    localparam int RANDOM_WORDS = 160;
    localparam int HOLD_CYCLES  = 400;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mpt_stream_if #(.T(t_in_word))  in_if ();
    mpt_stream_if #(.T(t_out_word)) out_if ();

    multichannel_pwm_timetable #(
        .CHANNELS (NCH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #5ns i_clk = ~i_clk;

    // timetable model
    logic [LVL_W-1:0]  stg_level [NCH];
    logic [PINS_W-1:0] stg_mask  [NCH];
    int                stg_count;
    logic [PINS_W-1:0] stg_on;
    logic [LVL_W-1:0]  act_level [NCH];
    logic [PINS_W-1:0] act_mask  [NCH];
    int                act_count;
    logic [PINS_W-1:0] act_on;
    int                entry_idx;
    logic [LVL_W-1:0]  cmp_level;
    logic [7:0]        tick_cnt;
    bit                commit_due;
    bit                batch_open;
    logic [PINS_W-1:0] pin_state;

    t_out_word pins_due [$];
    t_out_word due_word;
    int        err_count = 0;
    int        hold_req  = 0;
    int        snd_calm  = 0;
    int        rcv_calm  = 0;

    function automatic void clear_staging();
        foreach (stg_level[i]) begin
            stg_level[i] = '0;
            stg_mask[i]  = '0;
        end
        stg_count = 0;
        stg_on    = '0;
    endfunction

    function automatic void clear_model();
        clear_staging();
        foreach (act_level[i]) begin
            act_level[i] = '0;
            act_mask[i]  = '0;
        end
        act_count  = 0;
        act_on     = '0;
        entry_idx  = 0;
        cmp_level  = '0;
        tick_cnt   = '0;
        commit_due = 1'b0;
        batch_open = 1'b0;
        pin_state  = '0;
    endfunction

    function automatic void stage_channel(logic [CHAN_W-1:0] ch, logic [LVL_W-1:0] lvl);
        logic [PINS_W-1:0] bitm;
        int                pos;
        int                k;
        if (int'(ch) >= NCH || lvl == LVL_OFF) return;
        bitm     = '0;
        bitm[ch] = 1'b1;
        if (lvl == LVL_FULL) begin
            stg_on |= bitm;
            return;
        end
        pos = 0;
        while (pos < stg_count && stg_level[pos] < lvl) pos++;
        if (pos < stg_count && stg_level[pos] == lvl) begin
            stg_mask[pos] |= bitm;
            stg_on        |= bitm;
            return;
        end
        if (stg_count >= NCH) return;
        for (k = stg_count; k > pos; k--) begin
            stg_level[k] = stg_level[k-1];
            stg_mask[k]  = stg_mask[k-1];
        end
        stg_level[pos] = lvl;
        stg_mask[pos]  = bitm;
        stg_count++;
        stg_on |= bitm;
    endfunction

    function automatic void advance_tick();
        tick_cnt++;
        if (tick_cnt == 8'd0) begin
            if (commit_due) begin
                act_level  = stg_level;
                act_mask   = stg_mask;
                act_count  = stg_count;
                act_on     = stg_on;
                commit_due = 1'b0;
            end
            pin_state = act_on;
            entry_idx = 0;
            cmp_level = (act_count > 0) ? act_level[0] : '0;
            return;
        end
        if (entry_idx < act_count && tick_cnt == cmp_level) begin
            pin_state &= ~act_mask[entry_idx];
            entry_idx++;
            if (entry_idx < act_count) cmp_level = act_level[entry_idx];
        end
    endfunction

    function automatic t_out_word predict_pins(t_in_word w);
        t_out_word r;
        if (w.opcode == OP_TICK) begin
            advance_tick();
        end else begin
            if (!batch_open) begin
                clear_staging();
                commit_due = 1'b0;
                batch_open = 1'b1;
            end
            stage_channel(w.channel, w.brightness);
            if (w.last) begin
                commit_due = 1'b1;
                batch_open = 1'b0;
            end
        end
        r.pins = pin_state;
        return r;
    endfunction

    // idle at random between words, with occasional stretches of no idling
    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
        $display("%0t %s: expected pins %02h, got %02h", $time, what, want, got);
        err_count++;
    endtask

    task automatic send_word(input t_in_word w);
        int gap;
        gap = draw_wait(snd_calm);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
        pins_due.push_back(predict_pins(w));
    endtask

    task automatic send_tick();
        t_in_word w;
        w            = '0;
        w.opcode     = OP_TICK;
        w.channel    = CHAN_W'($urandom_range(0, NCH - 1));
        w.brightness = LVL_W'($urandom_range(0, 255));
        w.last       = 1'($urandom_range(0, 1));
        send_word(w);
    endtask

    task automatic send_load(int ch, int lvl, bit last);
        t_in_word w;
        w.opcode     = OP_LOAD;
        w.channel    = CHAN_W'(ch);
        w.brightness = LVL_W'(lvl);
        w.last       = last;
        send_word(w);
    endtask

    // run through the next wrap and on to the end of that period
    task automatic run_period();
        int n;
        n = 511 - int'(tick_cnt);
        repeat (n) send_tick();
    endtask

    function automatic int pick_level();
        unique case ($urandom_range(0, 7))
            0:       return int'(LVL_OFF);
            1:       return int'(LVL_FULL);
            2:       return 1;
            3:       return 254;
            4:       return (stg_count > 0) ? int'(stg_level[$urandom_range(0, stg_count - 1)])
                                            : $urandom_range(0, 255);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic test_idle_ticks();
        repeat (40) send_tick();
    endtask

    task automatic test_sorted_table();
        int lvls [NCH] = '{1, 254, 128, 2, 200, 64, 253, 3};
        foreach (lvls[i]) send_load(i, lvls[i], i == NCH - 1);
        run_period();
    endtask

    task automatic test_table_overflow();
        send_load(0, 10, 1'b0);
        send_load(1, 20, 1'b0);
        send_load(2, 30, 1'b0);
        send_load(3, int'(LVL_OFF), 1'b0);
        send_load(4, 40, 1'b0);
        send_load(5, 50, 1'b0);
        send_load(6, 60, 1'b0);
        send_load(7, int'(LVL_FULL), 1'b0);
        send_load(0, 70, 1'b0);
        send_load(1, 80, 1'b0);
        send_load(3, 90, 1'b0);
        send_load(4, 30, 1'b0);
        send_load(6, 60, 1'b1);
        run_period();
    endtask

    // leave the batch open; the next load closes it
    task automatic test_cancelled_commit();
        send_load(0, 200, 1'b1);
        send_load(1, 30, 1'b0);
        run_period();
    endtask

    task automatic test_back_pressure();
        hold_req = HOLD_CYCLES;
        send_load(6, 40, 1'b1);
        repeat (40) send_tick();
    endtask

    task automatic test_random_traffic();
        int       sent;
        int       n;
        t_in_word w;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if ($urandom_range(0, 9) < 8) begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++)
                    send_load($urandom_range(0, NCH - 1), pick_level(), i == n - 1);
                sent += n;
                n = $urandom_range(1, 48);
                repeat (n) send_tick();
                sent += n;
            end else begin
                n = $urandom_range(1, 20);
                repeat (n) begin
                    w            = '0;
                    w.opcode     = 1'($urandom_range(0, 1));
                    w.channel    = CHAN_W'($urandom_range(0, NCH - 1));
                    w.brightness = LVL_W'($urandom_range(0, 255));
                    w.last       = 1'($urandom_range(0, 1));
                    send_word(w);
                end
                sent += n;
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int gap;
        out_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req > 0) begin
                out_if.ready <= 1'b0;
                repeat (hold_req) @(posedge i_clk);
                hold_req = 0;
            end
            gap = draw_wait(rcv_calm);
            if (gap > 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pins_due.size() == 0) begin
                report_mismatch("unexpected word", 'x, out_if.data.pins);
            end else begin
                due_word = pins_due.pop_front();
                if (out_if.data.pins !== due_word.pins)
                    report_mismatch("pins", due_word.pins, out_if.data.pins);
            end
        end
    end

    initial begin
        in_if.valid <= 1'b0;
        in_if.data  <= '0;
        clear_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_ticks();
        test_sorted_table();
        test_table_overflow();
        test_cancelled_commit();
        test_back_pressure();
        test_random_traffic();
        in_if.valid <= 1'b0;
        wait (pins_due.size() == 0);
        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/mpt_pkg.sv
rtl/mpt_stream_if.sv
rtl/mpt_cell.sv
rtl/multichannel_pwm_timetable.sv
test/tb_multichannel_pwm_timetable.sv
